// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the box blur core.
// Included by the files that assert; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define RBB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// checked at every edge, reset included
`define RBB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");
`else
`define RBB_ASSERT(lbl, prop)
`define RBB_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/rbb_pkg.sv =====
// Types, constants and helper functions of the RGBA 3x3 box blur core.
// No dependencies; used by rbb_if.sv and rgba_box_blur_3x3_core.sv.
package rbb_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_W     = 16;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int SUM_W     = 12;
  localparam int DIV_SHIFT = 15;
  localparam int PROD_W    = SUM_W + 13;
  // ceil(2^15 / 6) and ceil(2^15 / 9): exact for sums up to 9 * 255
  localparam logic [12:0] DIV6_MUL = 13'd5462;
  localparam logic [12:0] DIV9_MUL = 13'd3641;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_e;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
  } out_item_t;

  // which window rows/columns lie inside the frame
  typedef struct packed {
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
    logic last;
  } geo_t;

  function automatic logic [7:0] div_chan(logic [SUM_W-1:0] sum, div_e dv);
    logic [PROD_W-1:0] prod;
    logic [7:0]        res;
    prod = '0;
    res  = '0;
    unique case (dv)
      DIV_4: res = sum[9:2];
      DIV_6: begin
        prod = PROD_W'(sum) * PROD_W'(DIV6_MUL);
        res  = prod[DIV_SHIFT +: 8];
      end
      DIV_9: begin
        prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
        res  = prod[DIV_SHIFT +: 8];
      end
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/rbb_if.sv =====
// Valid/ready channel interfaces of the box blur core: pixel in, result out,
// register writes. Depends on rbb_pkg for payload types and widths.
interface rbb_in_if;
  logic               valid;
  logic               ready;
  rbb_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbb_out_if;
  logic               valid;
  logic               ready;
  rbb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rbb_pkg::CFG_IDX_W-1:0]  index;
  logic [rbb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rgba_box_blur_3x3_core.sv =====
// Streaming 3x3 box mean over an RGBA frame in raster order. One pixel or flush
// transfer is taken per clock while in_ready is high. Two line buffers
// (MAX_WIDTH x 32 bit, each one read port at acceptance and one write port in
// the cycle after) and a 3x3 window register feed a three-stage pipe: line-buffer
// read, window shift, masked sum, then reciprocal division into an 8-entry
// result queue. A result follows the transfer that completes its window, i.e.
// one row plus one pixel after its own pixel; image_width+1 flush transfers drain
// the last row. in_ready depends only on a credit count of results in flight
// or queued: it drops once eight are outstanding. Line buffers need no clearing
// after reset. Depends on rbb_pkg, rbb_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module rgba_box_blur_3x3_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbb_in_if.sink    in_i,
  rbb_out_if.source out_o,
  rbb_cfg_if.sink   cfg_i
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = (WW > rbb_pkg::WIDTH_REG_W) ? WW : rbb_pkg::WIDTH_REG_W;
  localparam int HW   = rbb_pkg::HEIGHT_W;
  localparam int W_RST = (rbb_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                            : rbb_pkg::WIDTH_RESET;

  // frame geometry and position
  logic [WW-1:0] eff_w_q;
  logic [XW-1:0] wm1_q;
  logic [HW-1:0] eff_h_q, hm1_q;
  logic [XW-1:0] x_q, x_d;
  logic [HW-1:0] y_q, y_d;
  logic [WW-1:0] drain_q, drain_d;

  // config write
  logic          cfg_wr;
  logic [CW-1:0] w_ext, w_clamp;
  logic [HW-1:0] h_clamp;

  // acceptance
  logic          take, frame_active, ignore, keep, has, x_last, x_nz;
  logic [HW-1:0] cr;
  logic [XW-1:0] cc;
  rbb_pkg::geo_t geo;
  logic [31:0]   pix;

  // line buffers
  logic [31:0] upper_mem  [MAX_WIDTH];
  logic [31:0] middle_mem [MAX_WIDTH];
  logic [31:0] rd_up_q, rd_mid_q;

  // pipe
  logic          s1_valid_q, s1_has_q;
  logic [XW-1:0] s1_x_q;
  logic [31:0]   s1_pix_q;
  rbb_pkg::geo_t s1_geo_q;
  logic [31:0]   win_q [9];
  logic          s2_valid_q;
  rbb_pkg::geo_t s2_geo_q;
  logic [rbb_pkg::SUM_W-1:0] sum_d [3];
  logic [rbb_pkg::SUM_W-1:0] s3_sum_q [3];
  logic [2:0]    row_ok, col_ok;
  rbb_pkg::div_e div_d, s3_div_q;
  logic          s3_valid_q, s3_last_q;
  logic [7:0]    s3_alpha_q;
  rbb_pkg::out_item_t res;

  // result queue and credits
  rbb_pkg::out_item_t fifo_mem [rbb_pkg::FIFO_DEPTH];
  logic [rbb_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rbb_pkg::FIFO_CW-1:0] fill_q, credit_q;
  logic pop;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  always_comb begin
    w_ext = CW'(cfg_i.data[rbb_pkg::WIDTH_REG_W-1:0]);
    if (w_ext < CW'(2)) begin
      w_clamp = CW'(2);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_clamp = CW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    h_clamp = (cfg_i.data < HW'(2)) ? HW'(2) : cfg_i.data;
  end

  assign in_i.ready   = credit_q < rbb_pkg::FIFO_CW'(rbb_pkg::FIFO_DEPTH);
  assign take         = in_i.valid && in_i.ready;
  assign frame_active = y_q < eff_h_q;
  assign ignore       = frame_active ? (in_i.data.action == rbb_pkg::ACT_FLUSH)
                                     : (in_i.data.action == rbb_pkg::ACT_PIXEL);
  assign keep         = take && !ignore;
  assign x_last       = x_q == wm1_q;
  assign x_nz         = x_q != '0;

  always_comb begin
    if (frame_active) begin
      pix = {in_i.data.in_alpha, in_i.data.in_blue, in_i.data.in_green, in_i.data.in_red};
      cr  = x_nz ? y_q - HW'(1) : y_q - HW'(2);
      cc  = x_nz ? x_q - XW'(1) : wm1_q;
      has = x_nz ? (y_q != '0) : (y_q >= HW'(2));
    end else begin
      pix = '0;
      cr  = (drain_q == '0) ? hm1_q - HW'(1) : hm1_q;
      cc  = (drain_q == '0) ? wm1_q : XW'(drain_q - WW'(1));
      has = 1'b1;
    end
    geo.row_top   = cr != '0;
    geo.row_bot   = cr != hm1_q;
    geo.col_left  = cc != '0;
    geo.col_right = cc != wm1_q;
    geo.last      = !geo.row_bot && !geo.col_right;
  end

  always_comb begin
    x_d     = x_last ? '0 : XW'(x_q + XW'(1));
    y_d     = y_q;
    drain_d = drain_q;
    if (frame_active) begin
      if (x_last) begin
        y_d = y_q + HW'(1);
      end
    end else if (drain_q == eff_w_q) begin
      x_d     = '0;
      y_d     = '0;
      drain_d = '0;
    end else begin
      drain_d = drain_q + WW'(1);
    end
  end

  // line buffers: read at acceptance, write back in the following cycle
  always_ff @(posedge clk_i) begin
    if (keep) begin
      rd_up_q  <= upper_mem[x_q];
      rd_mid_q <= middle_mem[x_q];
    end
    if (s1_valid_q) begin
      upper_mem[s1_x_q]  <= rd_mid_q;
      middle_mem[s1_x_q] <= s1_pix_q;
    end
  end

  // masked window sums
  always_comb begin
    row_ok = {s2_geo_q.row_bot, 1'b1, s2_geo_q.row_top};
    col_ok = {s2_geo_q.col_right, 1'b1, s2_geo_q.col_left};
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_ok[r] && col_ok[c]) begin
            sum_d[ch] = sum_d[ch] + rbb_pkg::SUM_W'(win_q[r*3+c][8*ch +: 8]);
          end
        end
      end
    end
    if (s2_geo_q.row_top && s2_geo_q.row_bot && s2_geo_q.col_left && s2_geo_q.col_right) begin
      div_d = rbb_pkg::DIV_9;
    end else if ((s2_geo_q.row_top && s2_geo_q.row_bot)
                 || (s2_geo_q.col_left && s2_geo_q.col_right)) begin
      div_d = rbb_pkg::DIV_6;
    end else begin
      div_d = rbb_pkg::DIV_4;
    end
  end

  always_comb begin
    res.out_red   = rbb_pkg::div_chan(s3_sum_q[0], s3_div_q);
    res.out_green = rbb_pkg::div_chan(s3_sum_q[1], s3_div_q);
    res.out_blue  = rbb_pkg::div_chan(s3_sum_q[2], s3_div_q);
    res.out_alpha = s3_alpha_q;
    res.frame_end = s3_last_q;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (keep) begin
      s1_x_q   <= x_q;
      s1_pix_q <= pix;
      s1_has_q <= has;
      s1_geo_q <= geo;
    end
    if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= rd_up_q;
      win_q[5] <= rd_mid_q;
      win_q[8] <= s1_pix_q;
      s2_geo_q <= s1_geo_q;
    end
    if (s2_valid_q) begin
      s3_sum_q   <= sum_d;
      s3_div_q   <= div_d;
      s3_alpha_q <= win_q[4][31:24];
      s3_last_q  <= s2_geo_q.last;
    end
    if (s3_valid_q) begin
      fifo_mem[wr_ptr_q] <= res;
    end
  end

  assign pop         = out_o.valid && out_o.ready;
  assign out_o.valid = fill_q != '0;
  assign out_o.data  = fifo_mem[rd_ptr_q];

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q    <= WW'(W_RST);
      wm1_q      <= XW'(W_RST - 1);
      eff_h_q    <= HW'(rbb_pkg::HEIGHT_RESET);
      hm1_q      <= HW'(rbb_pkg::HEIGHT_RESET - 1);
      x_q        <= '0;
      y_q        <= '0;
      drain_q    <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
      credit_q   <= '0;
    end else begin
      if (cfg_wr && (cfg_i.index == rbb_pkg::REG_WIDTH
                     || cfg_i.index == rbb_pkg::REG_HEIGHT)) begin
        if (cfg_i.index == rbb_pkg::REG_WIDTH) begin
          eff_w_q <= WW'(w_clamp);
          wm1_q   <= XW'(w_clamp - CW'(1));
        end else begin
          eff_h_q <= h_clamp;
          hm1_q   <= h_clamp - HW'(1);
        end
        x_q     <= '0;
        y_q     <= '0;
        drain_q <= '0;
      end else if (keep) begin
        x_q     <= x_d;
        y_q     <= y_d;
        drain_q <= drain_d;
      end
      s1_valid_q <= keep;
      s2_valid_q <= s1_valid_q && s1_has_q;
      s3_valid_q <= s2_valid_q;
      if (s3_valid_q) begin
        wr_ptr_q <= wr_ptr_q + rbb_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + rbb_pkg::FIFO_AW'(1);
      end
      fill_q   <= fill_q + rbb_pkg::FIFO_CW'(s3_valid_q) - rbb_pkg::FIFO_CW'(pop);
      credit_q <= credit_q + rbb_pkg::FIFO_CW'(keep && has) - rbb_pkg::FIFO_CW'(pop);
    end
  end

  `RBB_ASSERT(a_credit_bound, credit_q <= rbb_pkg::FIFO_CW'(rbb_pkg::FIFO_DEPTH))
  `RBB_ASSERT(a_fill_le_credit, fill_q <= credit_q)
  `RBB_ASSERT(a_wb_after_take, s1_valid_q |-> $past(keep))
  `RBB_ASSERT(a_s3_from_s2, s3_valid_q |-> $past(s2_valid_q))

endmodule

// ===== bench/blur_checker.sv =====
// Scoreboard for the RGBA 3x3 box blur core: watches the pixel, result and
// register channels, predicts each blurred pixel and compares it field by field.
// Depends on rbb_pkg and the channel interfaces in rbb_if.sv.
module blur_checker #(
  parameter int MAX_W = 2048
) (
  input  logic clk_i,
  input  logic rst_ni,
  rbb_in_if    in_w,
  rbb_out_if   out_w,
  rbb_cfg_if   cfg_w,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   checked_o
);
  import rbb_pkg::*;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgba_t;

  rgba_t                  upper_line [MAX_W];
  rgba_t                  mid_line   [MAX_W];
  rgba_t                  win        [9];
  int unsigned            col_pos;
  int unsigned            row_pos;
  int unsigned            drain_pos;
  logic [WIDTH_REG_W-1:0] width_reg;
  logic [HEIGHT_W-1:0]    height_reg;
  out_item_t              blurred_q [$];
  int                     fail_cnt;
  int                     checked;

  function automatic int unsigned frame_w();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  // shift window left, load new column from the line buffers
  function automatic void slide_in(int unsigned x, rgba_t pix);
    if (x >= MAX_W) x = 0;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2]        = upper_line[x];
    win[5]        = mid_line[x];
    win[8]        = pix;
    upper_line[x] = mid_line[x];
    mid_line[x]   = pix;
  endfunction

  function automatic out_item_t box_mean(int unsigned cr, int unsigned cc,
                                         int unsigned w, int unsigned h);
    bit          rok [3];
    bit          cok [3];
    int unsigned sr, sg, sb, n;
    out_item_t   res;
    sr = 0; sg = 0; sb = 0; n = 0;
    rok[0] = cr >= 1; rok[1] = 1'b1; rok[2] = cr + 1 < h;
    cok[0] = cc >= 1; cok[1] = 1'b1; cok[2] = cc + 1 < w;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rok[r] && cok[c]) begin
          sr += win[r*3+c].r;
          sg += win[r*3+c].g;
          sb += win[r*3+c].b;
          n++;
        end
      end
    end
    res.out_red   = 8'(sr / n);
    res.out_green = 8'(sg / n);
    res.out_blue  = 8'(sb / n);
    res.out_alpha = win[4].a;
    res.frame_end = (cr == h - 1) && (cc == w - 1);
    return res;
  endfunction

  function automatic void take_item(in_item_t it);
    int unsigned w, h, x, y, cr, cc;
    bit          has;
    rgba_t       pix;
    w = frame_w();
    h = frame_h();
    x = col_pos;
    y = row_pos;
    if (y < h) begin
      if (it.action != ACT_PIXEL) return;
      pix.r = it.in_red;
      pix.g = it.in_green;
      pix.b = it.in_blue;
      pix.a = it.in_alpha;
      slide_in(x, pix);
      if (x >= 1) begin
        has = y >= 1; cr = y - 1; cc = x - 1;
      end else begin
        has = y >= 2; cr = y - 2; cc = w - 1;
      end
      x++;
      if (x >= w) begin
        x = 0;
        y++;
      end
      col_pos = x;
      row_pos = y;
      if (has) blurred_q.push_back(box_mean(cr, cc, w, h));
      return;
    end
    // frame complete: only flush transfers count
    if (it.action == ACT_PIXEL) return;
    pix = '0;
    slide_in(x, pix);
    if (drain_pos == 0) begin
      cr = h - 2; cc = w - 1;
    end else begin
      cr = h - 1; cc = drain_pos - 1;
    end
    blurred_q.push_back(box_mean(cr, cc, w, h));
    x++;
    if (x >= w) x = 0;
    col_pos = x;
    drain_pos++;
    if (drain_pos >= w + 1) begin
      col_pos = 0; row_pos = 0; drain_pos = 0;
    end
  endfunction

  task automatic report_mismatch(string fld, int got, int want);
    $display("blurred pixel %0d: %s is %0d, predicted %0d", checked, fld, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got, want;
    if (!rst_ni) begin
      foreach (upper_line[k]) upper_line[k] = '0;
      foreach (mid_line[k]) mid_line[k] = '0;
      foreach (win[k]) win[k] = '0;
      col_pos = 0; row_pos = 0; drain_pos = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      blurred_q.delete();
      fail_cnt = 0;
      checked  = 0;
    end else begin
      if (out_w.valid && out_w.ready) begin
        got = out_w.data;
        if (blurred_q.size() == 0) begin
          $display("blurred pixel %0d: result with nothing pending", checked);
          fail_cnt++;
        end else begin
          want = blurred_q.pop_front();
          if (got.out_red !== want.out_red)
            report_mismatch("red", got.out_red, want.out_red);
          if (got.out_green !== want.out_green)
            report_mismatch("green", got.out_green, want.out_green);
          if (got.out_blue !== want.out_blue)
            report_mismatch("blue", got.out_blue, want.out_blue);
          if (got.out_alpha !== want.out_alpha)
            report_mismatch("alpha", got.out_alpha, want.out_alpha);
          if (got.frame_end !== want.frame_end)
            report_mismatch("frame_end", got.frame_end, want.frame_end);
        end
        checked++;
      end
      if (cfg_w.valid && cfg_w.ready) begin
        if (cfg_w.index == REG_WIDTH) begin
          width_reg = cfg_w.data[WIDTH_REG_W-1:0];
          col_pos = 0; row_pos = 0; drain_pos = 0;
        end else if (cfg_w.index == REG_HEIGHT) begin
          height_reg = cfg_w.data[HEIGHT_W-1:0];
          col_pos = 0; row_pos = 0; drain_pos = 0;
        end
      end
      if (in_w.valid && in_w.ready) take_item(in_w.data);
    end
    fail_cnt_o <= fail_cnt;
    pending_o  <= blurred_q.size();
    checked_o  <= checked;
  end

endmodule

// ===== bench/tb_rgba_box_blur_3x3_core.sv =====
// Testbench top for rgba_box_blur_3x3_core: clock, reset, frame stimulus with
// random idling and stalls, and the verdict. Checking lives in blur_checker.sv;
// needs rbb_pkg, rbb_if.sv and the core.
module tb_rgba_box_blur_3x3_core;
  import rbb_pkg::*;

  localparam int   MAX_W        = 2048;
  localparam int   LIMIT        = 1000000;
  localparam int   RANDOM_ITEMS = 300;
  localparam int   CALM_TAIL    = 100;
  localparam int   PAT_RANDOM   = 0;
  localparam int   PAT_CORNERS  = 1;
  localparam int   PAT_RAMP     = 2;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending, checked;
  int   cycles      = 0;
  int   sent_items  = 0;
  int   frames_done = 0;
  int   calm_from   = 32'h7fffffff;
  bit   calm        = 1'b0;
  bit   tx_choppy   = 1'b1;

  always #1 clk_i = ~clk_i;

  rbb_in_if  pix_ch ();
  rbb_out_if blur_ch ();
  rbb_cfg_if reg_ch ();

  rgba_box_blur_3x3_core #(.MAX_WIDTH(MAX_W)) uut (
    .clk_i,
    .rst_ni,
    .in_i  (pix_ch),
    .out_o (blur_ch),
    .cfg_i (reg_ch)
  );

  blur_checker #(.MAX_W(MAX_W)) u_check (
    .clk_i,
    .rst_ni,
    .in_w       (pix_ch),
    .out_w      (blur_ch),
    .cfg_w      (reg_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("rgba_box_blur_3x3_core test failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_chan();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t random_item(logic act);
    in_item_t it;
    it.action   = act;
    it.in_red   = rand_chan();
    it.in_green = rand_chan();
    it.in_blue  = rand_chan();
    it.in_alpha = rand_chan();
    return it;
  endfunction

  function automatic in_item_t make_pixel(int pat, int idx);
    in_item_t it;
    it = random_item(ACT_PIXEL);
    if (pat == PAT_CORNERS) begin
      it.in_red   = idx[0] ? 8'h00 : 8'hff;
      it.in_green = idx[1] ? 8'hff : 8'h00;
      it.in_blue  = (idx == 0) ? 8'hff : 8'h00;
      it.in_alpha = (idx == 3) ? 8'h00 : 8'hff;
    end else if (pat == PAT_RAMP) begin
      it.in_red   = 8'hff;
      it.in_green = 8'h00;
      it.in_blue  = 8'(idx * 31);
      it.in_alpha = 8'(255 - idx * 17);
    end
    return it;
  endfunction

  task automatic push_item(in_item_t it, bit counts);
    if (!calm && tx_choppy && $urandom_range(0, 5) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= it;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
    if (counts) sent_items++;
    if (sent_items >= calm_from) calm = 1'b1;
  endtask

  // registers change only with the core drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    pix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val;
    @(posedge clk_i);
    while (!reg_ch.ready) @(posedge clk_i);
    reg_ch.valid <= 1'b0;
  endtask

  task automatic set_geometry(int wraw, int hraw, output int w, output int h);
    write_reg(REG_WIDTH, CFG_DATA_W'(wraw));
    write_reg(REG_HEIGHT, CFG_DATA_W'(hraw));
    w = (wraw < 2) ? 2 : ((wraw > MAX_W) ? MAX_W : wraw);
    h = (hraw < 2) ? 2 : hraw;
  endtask

  // npix below w*h leaves the frame unfinished, no drain
  task automatic send_frame(int w, int h, int npix, int pat, int early_flush_at,
                            int drain_pix_at, bit noisy);
    tx_choppy = $urandom_range(0, 2) != 0;
    for (int i = 0; i < npix; i++) begin
      if (i == early_flush_at || (noisy && $urandom_range(0, 39) == 0))
        push_item(random_item(ACT_FLUSH), 1'b0);
      push_item(make_pixel(pat, i), 1'b1);
    end
    if (npix == w * h) begin
      for (int j = 0; j <= w; j++) begin
        if (j == drain_pix_at || (noisy && $urandom_range(0, 29) == 0))
          push_item(random_item(ACT_PIXEL), 1'b0);
        push_item(random_item(ACT_FLUSH), 1'b1);
      end
      frames_done++;
    end
  endtask

  // result side: short random stalls, one long hold-off to back up the core
  initial begin
    int stall_left, rx_seen, mode_left;
    bit long_done, rx_choppy;
    stall_left = 0; rx_seen = 0; mode_left = 0;
    long_done  = 1'b0; rx_choppy = 1'b0;
    blur_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (blur_ch.valid && blur_ch.ready) rx_seen++;
      if (mode_left == 0) begin
        rx_choppy = $urandom_range(0, 2) != 0;
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        blur_ch.ready <= 1'b0;
      end else if (!calm && !long_done && rx_seen >= 24) begin
        long_done  = 1'b1;
        stall_left = 150;
        blur_ch.ready <= 1'b0;
      end else if (!calm && rx_choppy && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        blur_ch.ready <= 1'b0;
      end else begin
        blur_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int w, h, wraw, hraw, npix, sel, target;
    pix_ch.valid <= 1'b0;
    pix_ch.data  <= '0;
    reg_ch.valid <= 1'b0;
    reg_ch.index <= REG_WIDTH;
    reg_ch.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: a bit over one row at 640 wide
    send_frame(WIDTH_RESET, HEIGHT_RESET, 650, PAT_RANDOM, -1, -1, 1'b0);

    // out-of-range registers act as 2x2; stray flush mid-frame, pixel mid-drain
    set_geometry(0, 1, w, h);
    send_frame(w, h, w * h, PAT_CORNERS, 2, 1, 1'b0);
    set_geometry(3, 3, w, h);
    send_frame(w, h, w * h, PAT_RAMP, -1, -1, 1'b0);

    // the receiver holds off during this frame, so the core backs up
    set_geometry(9, 7, w, h);
    send_frame(w, h, w * h, PAT_RANDOM, -1, -1, 1'b0);

    target    = sent_items + RANDOM_ITEMS;
    calm_from = target - CALM_TAIL;
    while (sent_items < target) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        wraw = $urandom_range(0, 1);
        hraw = $urandom_range(0, 5);
      end else if (sel == 1) begin
        wraw = $urandom_range(2, 6);
        hraw = 65535;
      end else if (sel == 2) begin
        wraw = $urandom_range(20, 64);
        hraw = $urandom_range(2, 4);
      end else begin
        wraw = $urandom_range(2, 9);
        hraw = $urandom_range(0, 7);
      end
      set_geometry(wraw, hraw, w, h);
      if (sel == 1)
        npix = w * $urandom_range(1, 4) + $urandom_range(0, w - 1);
      else if ($urandom_range(0, 7) == 0)
        npix = $urandom_range(1, w * h - 1);
      else
        npix = w * h;
      send_frame(w, h, npix, PAT_RANDOM, -1, -1, 1'b1);
    end

    pix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d pixel/flush transfers, %0d complete frames, %0d blurred pixels checked",
             sent_items, frames_done, checked);
    $display("geometries from 2x2 to 640 wide, stray flushes, drain-time pixels, cut frames");
    if (fail_cnt == 0) begin
      $display("rgba_box_blur_3x3_core test passed");
    end else begin
      $display("rgba_box_blur_3x3_core test failed");
    end
    $finish;
  end

endmodule
